// ----- design/constant_color_over_blend_macros.svh -----
// assertion macros for the blend block
`ifndef CONSTANT_COLOR_OVER_BLEND_MACROS_SVH
`define CONSTANT_COLOR_OVER_BLEND_MACROS_SVH
// implication checked on every clock unless reset
`define CCOB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define CCOB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- design/ccob_pkg.sv -----
// ----------------------------------------------------------------------------
// ccob_pkg
// types and constants shared by the fill-over-source blend pipeline
// ----------------------------------------------------------------------------
package ccob_pkg;
   localparam int unsigned NUM_BITS   = 16;   // quotient bits resolved, one per cell
   localparam logic [7:0] MAX8 = 8'd255;
   localparam logic [1:0] REG_FILL_RED   = 2'd0;
   localparam logic [1:0] REG_FILL_GREEN = 2'd1;
   localparam logic [1:0] REG_FILL_BLUE  = 2'd2;
   localparam logic [1:0] REG_FILL_ALPHA = 2'd3;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } rsp_type;

   // one division lane: partial remainder, numerator bits still to enter, quotient
   typedef struct packed {
      logic [16:0] rem;
      logic [15:0] num;
      logic [15:0] quo;
   } lane_type;

   // everything one cell hands to its neighbor
   typedef struct packed {
      logic        valid;
      lane_type    red;
      lane_type    green;
      lane_type    blue;
      logic [15:0] den;
      logic [7:0]  alpha;
      logic        zero;
      logic [23:0] pass;
   } cell_type;
endpackage

// ----- design/constant_color_over_blend.sv -----
// ----------------------------------------------------------------------------
// constant_color_over_blend
// porter-duff over of a constant fill color onto a stream of rgba8 pixels
// ----------------------------------------------------------------------------
// path: a pixel passes 2 front steps, 16 cells and 1 output register from req
//    transfer to rsp valid, waiting longer only while rsp_stall holds the pipe
// throughput: one pixel per cycle; the whole chain advances when the output
//    register is free or being drained
// reset: synchronous, clears all valid bits and loads the fill registers
//    with opaque red
module constant_color_over_blend import ccob_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   // fill color registers
   logic [7:0] fill_r_ff, fill_g_ff, fill_b_ff, fill_a_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   logic       advance;

   // chain of division cells, slot 0 fed by the front end
   cell_type chain [NUM_BITS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_r_ff <= MAX8;
         fill_g_ff <= 8'd0;
         fill_b_ff <= 8'd0;
         fill_a_ff <= MAX8;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FILL_RED:   fill_r_ff <= csr_data;
            REG_FILL_GREEN: fill_g_ff <= csr_data;
            REG_FILL_BLUE:  fill_b_ff <= csr_data;
            REG_FILL_ALPHA: fill_a_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // the pipe moves whenever the output slot is empty or drains this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   ccob_front u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_pix   (req_data),
      .fill_r   (fill_r_ff),
      .fill_g   (fill_g_ff),
      .fill_b   (fill_b_ff),
      .fill_a   (fill_a_ff),
      .out_cell (chain[0])
   );

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
      ccob_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_cell  (chain[i]),
         .out_cell (chain[i+1])
      );
   end

   // output register; zero denominator passes the source color through
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= chain[NUM_BITS].valid;
      if (advance) begin
         if (chain[NUM_BITS].zero) begin
            rsp_data_ff <= {chain[NUM_BITS].pass, 8'd0};
         end else begin
            rsp_data_ff <= {chain[NUM_BITS].red.quo[7:0], chain[NUM_BITS].green.quo[7:0],
                            chain[NUM_BITS].blue.quo[7:0], chain[NUM_BITS].alpha};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ----- design/ccob_front.sv -----
// ----------------------------------------------------------------------------
// ccob_front
// forms weighted numerators and the common denominator over two registered steps
// ----------------------------------------------------------------------------
module ccob_front import ccob_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  req_type   in_pix,
   input  logic [7:0] fill_r,
   input  logic [7:0] fill_g,
   input  logic [7:0] fill_b,
   input  logic [7:0] fill_a,
   output cell_type  out_cell
);
   // step one: alpha weights and products
   logic        v1_ff;
   req_type     pix_ff;
   logic [15:0] wf_ff, ws_ff;     // A*255 and Pa*(255-A)
   logic [7:0]  cr_ff, cg_ff, cb_ff;
   cell_type    cell_ff, cell_in;
   logic [16:0] den_w;
   logic [23:0] nr, ng, nb;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         cell_ff.valid <= cell_in.valid;
      end
      if (advance) begin
         pix_ff <= in_pix;
         wf_ff  <= 16'(fill_a) * 16'(MAX8);
         ws_ff  <= 16'(in_pix.src_alpha) * 16'(MAX8 - fill_a);
         cr_ff  <= fill_r;
         cg_ff  <= fill_g;
         cb_ff  <= fill_b;
         {cell_ff.red, cell_ff.green, cell_ff.blue} <=
            {cell_in.red, cell_in.green, cell_in.blue};
         cell_ff.den   <= cell_in.den;
         cell_ff.alpha <= cell_in.alpha;
         cell_ff.zero  <= cell_in.zero;
         cell_ff.pass  <= cell_in.pass;
      end
   end

   // step two: numerators C*wf + P*ws, at most 255*65025 < 2^24
   always_comb begin
      den_w = 17'(wf_ff) + 17'(ws_ff);
      nr = 24'(cr_ff) * 24'(wf_ff) + 24'(pix_ff.src_red) * 24'(ws_ff);
      ng = 24'(cg_ff) * 24'(wf_ff) + 24'(pix_ff.src_green) * 24'(ws_ff);
      nb = 24'(cb_ff) * 24'(wf_ff) + 24'(pix_ff.src_blue) * 24'(ws_ff);
      cell_in.valid = v1_ff;
      cell_in.den   = den_w[15:0];
      // den/255 by reciprocal: (den*257+257)>>16 is exact for den < 65536
      cell_in.alpha = 8'((25'(den_w) * 25'd257 + 25'd257) >> 16);
      cell_in.zero  = (den_w == 17'd0);
      cell_in.pass  = {pix_ff.src_red, pix_ff.src_green, pix_ff.src_blue};
      // numerator bits enter the remainder one per cell, top 8 bits preloaded
      cell_in.red   = '{rem: 17'(nr[23:16]), num: nr[15:0], quo: '0};
      cell_in.green = '{rem: 17'(ng[23:16]), num: ng[15:0], quo: '0};
      cell_in.blue  = '{rem: 17'(nb[23:16]), num: nb[15:0], quo: '0};
   end
   assign out_cell = cell_ff;
endmodule

// ----- design/ccob_cell.sv -----
// ----------------------------------------------------------------------------
// ccob_cell
// one restoring-division step for all three channel lanes, registered
// ----------------------------------------------------------------------------
module ccob_cell import ccob_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type in_cell,
   output cell_type out_cell
);
   cell_type cell_ff, cell_in;

   function automatic lane_type step(lane_type l, logic [15:0] d);
      logic [17:0] t;
      lane_type r;
      t = {l.rem, l.num[15]};
      r.num = {l.num[14:0], 1'b0};
      if (t >= 18'(d)) begin
         r.rem = 17'(t - 18'(d));
         r.quo = {l.quo[14:0], 1'b1};
      end else begin
         r.rem = t[16:0];
         r.quo = {l.quo[14:0], 1'b0};
      end
      return r;
   endfunction

   always_comb begin
      cell_in = in_cell;
      cell_in.red   = step(in_cell.red, in_cell.den);
      cell_in.green = step(in_cell.green, in_cell.den);
      cell_in.blue  = step(in_cell.blue, in_cell.den);
   end

   always_ff @(posedge clock) begin
      if (reset) cell_ff.valid <= 1'b0;
      else if (advance) cell_ff.valid <= cell_in.valid;
      if (advance) begin
         {cell_ff.red, cell_ff.green, cell_ff.blue, cell_ff.den, cell_ff.alpha,
          cell_ff.zero, cell_ff.pass} <=
         {cell_in.red, cell_in.green, cell_in.blue, cell_in.den, cell_in.alpha,
          cell_in.zero, cell_in.pass};
      end
   end
   assign out_cell = cell_ff;
endmodule

// ----- design/ccob_checker.sv -----
// ----------------------------------------------------------------------------
// ccob_checker
// port-level checks on the blend block's stream behavior
// ----------------------------------------------------------------------------
`include "constant_color_over_blend_macros.svh"
module ccob_checker import ccob_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    csr_ready
);
   `CCOB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CCOB_ASSERT_IMP(a_no_stall_free, clock, reset, !rsp_valid, !req_stall)
   `CCOB_ASSERT_IMP(a_stall_follows, clock, reset, req_stall, rsp_valid && rsp_stall)
   `CCOB_ASSERT_IMP(a_csr_ready, clock, reset, 1'b1, csr_ready)
endmodule

bind constant_color_over_blend ccob_checker u_ccob_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
